// File: rtl/modbus_rtu_sensor_master_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MODBUS_RTU_SENSOR_MASTER_CORE_ASSERT_SVH
`define MODBUS_RTU_SENSOR_MASTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MRSM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("modbus core: same-cycle check failed");

// Next-cycle implication.
`define MRSM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("modbus core: next-cycle check failed");

`endif

// File: rtl/mrsm_pkg.sv
package mrsm_pkg;

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_AIR  = 2'd2;
    localparam logic [1:0] OP_ZERO = 2'd3;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_CONFIRM = 2'd2;

    localparam logic [7:0] FUNC_READ  = 8'h03;
    localparam logic [7:0] FUNC_WRITE = 8'h06;
    localparam logic [7:0] REG_AIR    = 8'h1A;
    localparam logic [7:0] REG_ZERO   = 8'h1C;
    localparam logic [7:0] QTY_READ   = 8'h06;
    localparam logic [7:0] VAL_CAL    = 8'h01;
    localparam logic [7:0] RESP_BYTES = 8'h0C;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] ADDR_RESET = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int RX_LEN      = 17;
    localparam int FRAME_LEN   = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;

    typedef struct packed {
        logic       send;
        logic       cal;
        logic [7:0] func;
        logic [7:0] addr_lo;
        logic [7:0] qty_lo;
        logic [7:0] rx_byte;
    } cmd_t;

endpackage

// File: rtl/mrsm_front.sv
module mrsm_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mrsm_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output mrsm_pkg::cmd_t                    cmd
);

    logic           hold_valid_reg;
    mrsm_pkg::cmd_t hold_reg;
    mrsm_pkg::cmd_t hold_next;

    assign s_tready  = !hold_valid_reg || cmd_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb begin
        hold_next         = '0;
        hold_next.rx_byte = s_tdata;
        unique case (s_tuser)
            mrsm_pkg::OP_RX: begin
                hold_next.send = 1'b0;
            end
            mrsm_pkg::OP_READ: begin
                hold_next.send    = 1'b1;
                hold_next.func    = mrsm_pkg::FUNC_READ;
                hold_next.addr_lo = mrsm_pkg::ZERO_BYTE;
                hold_next.qty_lo  = mrsm_pkg::QTY_READ;
            end
            mrsm_pkg::OP_AIR: begin
                hold_next.send    = 1'b1;
                hold_next.cal     = 1'b1;
                hold_next.func    = mrsm_pkg::FUNC_WRITE;
                hold_next.addr_lo = mrsm_pkg::REG_AIR;
                hold_next.qty_lo  = mrsm_pkg::VAL_CAL;
            end
            default: begin
                hold_next.send    = 1'b1;
                hold_next.cal     = 1'b1;
                hold_next.func    = mrsm_pkg::FUNC_WRITE;
                hold_next.addr_lo = mrsm_pkg::REG_ZERO;
                hold_next.qty_lo  = mrsm_pkg::VAL_CAL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tready) begin
            hold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_reg <= hold_next;
        end
    end

endmodule

// File: rtl/mrsm_fifo.sv
module mrsm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  mrsm_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mrsm_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mrsm_pkg::cmd_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/mrsm_back.sv
module mrsm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [7:0]                        slave_address,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  mrsm_pkg::cmd_t                    pop_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mrsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    typedef enum logic [1:0] {
        B_FETCH = 2'b01,
        B_SEND  = 2'b10
    } back_state_t;

    localparam logic [2:0] IDX_CRC_LO = 3'd6;
    localparam logic [2:0] IDX_LAST   = 3'(mrsm_pkg::FRAME_LEN - 1);
    localparam logic [4:0] ECHO_COUNT = 5'(mrsm_pkg::FRAME_LEN);
    localparam logic [4:0] FULL_COUNT = 5'(mrsm_pkg::RX_LEN);

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ mrsm_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    back_state_t    state_reg;
    mrsm_pkg::cmd_t cur_reg;
    logic [2:0]     idx_reg;
    logic [15:0]    crc_reg;
    logic [7:0]     rx_store_reg [mrsm_pkg::RX_LEN];
    logic [7:0]     sent_frame_reg [mrsm_pkg::FRAME_LEN];
    logic [4:0]     rx_count_reg;
    logic           echo_pending_reg;

    logic           m_valid_reg;
    logic [1:0]     m_kind_reg;
    logic [7:0]     m_tx_reg;
    logic [31:0]    m_ox_reg;
    logic [31:0]    m_sat_reg;
    logic [31:0]    m_temp_reg;
    logic           m_last_reg;

    logic           load_ok;
    logic           in_send;
    mrsm_pkg::cmd_t cmd_sel;
    logic [2:0]     idx_sel;
    logic [15:0]    crc_sel;
    logic [7:0]     frame_byte;
    logic [15:0]    crc_step;
    logic           send_step;
    logic           rx_step;
    logic [7:0]     rx_byte;
    logic [4:0]     cnt1;
    logic           echo_same;
    logic           echo_hit;
    logic           full;
    logic           hdr_ok;
    logic           emit_rx;
    logic [1:0]     kind_next;
    logic [7:0]     tx_next;
    logic [31:0]    ox_next;
    logic [31:0]    sat_next;
    logic [31:0]    temp_next;
    logic           last_next;

    assign load_ok   = !m_valid_reg || m_tready;
    assign in_send   = state_reg == B_SEND;
    assign cmd_sel   = in_send ? cur_reg : pop_data;
    assign idx_sel   = in_send ? idx_reg : 3'd0;
    assign crc_sel   = in_send ? crc_reg : mrsm_pkg::CRC_INIT;
    assign pop_ready = !in_send && load_ok;
    assign send_step = load_ok && (in_send || (pop_valid && pop_data.send));
    assign rx_step   = !in_send && load_ok && pop_valid && !pop_data.send;
    assign rx_byte   = pop_data.rx_byte;
    assign cnt1      = rx_count_reg + 5'd1;
    assign full      = cnt1 == FULL_COUNT;
    assign crc_step  = crc_update(crc_sel, frame_byte);

    always_comb begin
        case (idx_sel)
            3'd0:    frame_byte = slave_address;
            3'd1:    frame_byte = cmd_sel.func;
            3'd2:    frame_byte = mrsm_pkg::ZERO_BYTE;
            3'd3:    frame_byte = cmd_sel.addr_lo;
            3'd4:    frame_byte = mrsm_pkg::ZERO_BYTE;
            3'd5:    frame_byte = cmd_sel.qty_lo;
            3'd6:    frame_byte = crc_sel[7:0];
            default: frame_byte = crc_sel[15:8];
        endcase
    end

    always_comb begin
        echo_same = rx_byte == sent_frame_reg[mrsm_pkg::FRAME_LEN-1];
        for (int i = 0; i < mrsm_pkg::FRAME_LEN - 1; i++) begin
            echo_same = echo_same && (rx_store_reg[i] == sent_frame_reg[i]);
        end
    end

    assign echo_hit = echo_pending_reg && (cnt1 == ECHO_COUNT) && echo_same;
    assign hdr_ok   = (rx_store_reg[0] == slave_address)
                   && (rx_store_reg[1] == mrsm_pkg::FUNC_READ)
                   && (rx_store_reg[2] == mrsm_pkg::RESP_BYTES);
    assign emit_rx  = rx_step && (echo_hit || (full && hdr_ok));

    always_comb begin
        kind_next = mrsm_pkg::KIND_MEASURE;
        tx_next   = '0;
        ox_next   = {rx_store_reg[3], rx_store_reg[4], rx_store_reg[5], rx_store_reg[6]};
        sat_next  = {rx_store_reg[7], rx_store_reg[8], rx_store_reg[9], rx_store_reg[10]};
        temp_next = {rx_store_reg[11], rx_store_reg[12], rx_store_reg[13], rx_store_reg[14]};
        last_next = 1'b1;
        if (send_step) begin
            kind_next = mrsm_pkg::KIND_TX;
            tx_next   = frame_byte;
            last_next = idx_sel == IDX_LAST;
        end else if (echo_hit) begin
            kind_next = mrsm_pkg::KIND_CONFIRM;
        end
        if (send_step || echo_hit) begin
            ox_next   = '0;
            sat_next  = '0;
            temp_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= B_FETCH;
            m_valid_reg      <= 1'b0;
            rx_count_reg     <= '0;
            echo_pending_reg <= 1'b0;
        end else begin
            if (load_ok) begin
                m_valid_reg <= send_step || emit_rx;
            end
            unique case (state_reg)
                B_FETCH: begin
                    if (send_step) begin
                        state_reg <= B_SEND;
                        if (pop_data.cal) begin
                            echo_pending_reg <= 1'b1;
                        end
                    end
                end
                B_SEND: begin
                    if (load_ok && idx_reg == IDX_LAST) begin
                        state_reg <= B_FETCH;
                    end
                end
                default: state_reg <= B_FETCH;
            endcase
            if (rx_step) begin
                if (echo_hit) begin
                    echo_pending_reg <= 1'b0;
                    rx_count_reg     <= '0;
                end else if (full) begin
                    rx_count_reg <= '0;
                end else begin
                    rx_count_reg <= cnt1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (send_step) begin
            idx_reg <= idx_sel + 3'd1;
            if (idx_sel < IDX_CRC_LO) begin
                crc_reg <= crc_step;
            end
            if (!in_send) begin
                cur_reg <= pop_data;
            end
            if (cmd_sel.cal) begin
                sent_frame_reg[idx_sel] <= frame_byte;
            end
        end
        if (rx_step) begin
            rx_store_reg[rx_count_reg] <= rx_byte;
        end
        if (load_ok) begin
            m_kind_reg <= kind_next;
            m_tx_reg   <= tx_next;
            m_ox_reg   <= ox_next;
            m_sat_reg  <= sat_next;
            m_temp_reg <= temp_next;
            m_last_reg <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_temp_reg, m_sat_reg, m_ox_reg, m_tx_reg};

endmodule

// File: rtl/modbus_rtu_sensor_master_core.sv
// Channel   Direction  Content
// s_        in         operation (tuser), received byte (tdata)
// m_        out        result kind (tuser), frame byte and sensor words (tdata), tlast
// cfg_      in         slave address write
//
// A send command goes out on the back sequencer one frame byte per cycle unless the output
// stalls, with the CRC taken over the first six bytes; received bytes wait while a frame goes out.
// Commands wait in a QUEUE_DEPTH entry queue, so input keeps flowing while frames go out.
// Output stalls freeze the back sequencer; input stalls only when the queue fills.
// Reset is synchronous and active low; slave address resets to 1.
module modbus_rtu_sensor_master_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mrsm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                        s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mrsm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] tx_byte, [39:8] oxygen_bits,
                                                         // [71:40] saturation_bits,
                                                         // [103:72] temperature_bits
    output logic [1:0]                        m_tuser,   // [1:0] result_kind
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [7:0]                        cfg_data
);

    logic [7:0]     slave_address_reg;
    logic           front_valid;
    logic           front_ready;
    mrsm_pkg::cmd_t front_cmd;
    logic           queue_valid;
    logic           queue_ready;
    mrsm_pkg::cmd_t queue_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= mrsm_pkg::ADDR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            slave_address_reg <= cfg_data;
        end
    end

    mrsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    mrsm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    mrsm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .slave_address (slave_address_reg),
        .pop_valid     (queue_valid),
        .pop_ready     (queue_ready),
        .pop_data      (queue_cmd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

// File: rtl/mrsm_checker.sv
`include "modbus_rtu_sensor_master_core_assert.svh"

module mrsm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mrsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                        m_tuser,
    input logic                              m_tlast
);

    `MRSM_ASSERT_SAME(a_event_is_last, aclk, aresetn, m_tvalid && (m_tuser != mrsm_pkg::KIND_TX), m_tlast)
    `MRSM_ASSERT_SAME(a_event_no_byte, aclk, aresetn, m_tvalid && (m_tuser != mrsm_pkg::KIND_TX), m_tdata[7:0] == 8'h00)
    `MRSM_ASSERT_SAME(a_words_measure, aclk, aresetn, m_tvalid && (m_tuser != mrsm_pkg::KIND_MEASURE), m_tdata[103:8] == '0)
    `MRSM_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind modbus_rtu_sensor_master_core mrsm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
